/* rtl/lla_pkg.sv */
// Shared types, codes and helpers for the bottom-aligned line layout block.
package lla_pkg;

    localparam int LINE_RUNS_DEF = 32;
    localparam int LIST_RUNS_DEF = 1024;
    localparam int QUEUE_DEPTH   = 4;

    localparam int IDX_W  = 10;
    localparam int SIZE_W = 16;
    localparam int POS_W  = 20;

    typedef enum logic [1:0] {
        KIND_PLACE    = 2'd0,
        KIND_SIZE     = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    // One command from the front end to the back end.
    typedef struct packed {
        logic              st;   // store a box entry
        logic              ovf;  // report a dropped box
        logic              cls;  // close the open line
        logic              sz;   // report the block size afterwards
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  x;
        logic [SIZE_W-1:0] h;
        logic [SIZE_W-1:0] lh;   // height of the line being closed
        logic [POS_W-1:0]  lw;   // width of the line being closed
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  x;
        logic [SIZE_W-1:0] h;
    } entry_t;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {{(POS_W + 1 - SIZE_W){1'b0}}, b};
        return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

endpackage

/* rtl/line_layout_bottom_align.sv */
// Top level of the bottom-aligned line layout block.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | is_break, run_width, run_height, last_run
//  m_      | out       | m_valid / m_ready  | kind, run_index, pos_x, pos_y, last_result
//
// The front end takes one run per cycle while the command queue has room. The back end
// writes each box into the line store and, when a line closes, first starts the store
// read and then gives one placement result per box of the line, in store order, each
// as soon as the result register is free.
// Reset is synchronous and active low; it clears the pen, counters, queue and result
// valid, while the line store itself is not cleared.
// A stalled result register holds the back end, and a full queue then drops s_ready;
// the front end keeps accepting runs for as long as the queue has space.
module line_layout_bottom_align
    import lla_pkg::*;
#(
    parameter int LINE_RUNS = LINE_RUNS_DEF,
    parameter int LIST_RUNS = LIST_RUNS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_is_break,
    input  logic [SIZE_W-1:0] s_run_width,
    input  logic [SIZE_W-1:0] s_run_height,
    input  logic              s_last_run,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [IDX_W-1:0]  m_run_index,
    output logic [POS_W-1:0]  m_pos_x,
    output logic [POS_W-1:0]  m_pos_y,
    output logic              m_last_result
);

    // Command transactions between the front end and the back end.
    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic full;
    logic pop;
    logic empty;

    // The front end classifies each run against the line fill it mirrors.
    lla_front #(
        .LINE_RUNS (LINE_RUNS),
        .LIST_RUNS (LIST_RUNS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_is_break   (s_is_break),
        .s_run_width  (s_run_width),
        .s_run_height (s_run_height),
        .s_last_run   (s_last_run),
        .q_push       (push),
        .q_cmd        (push_cmd),
        .q_full       (full)
    );

    lla_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    // The back end owns the line store and the vertical pen.
    lla_back #(
        .LINE_RUNS (LINE_RUNS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_cmd         (pop_cmd),
        .q_empty       (empty),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_run_index   (m_run_index),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_last_result (m_last_result)
    );

endmodule

/* rtl/lla_front.sv */
// Front end: accepts runs, tracks the pen and line fill, and issues commands.
module lla_front
    import lla_pkg::*;
#(
    parameter int LINE_RUNS = LINE_RUNS_DEF,
    parameter int LIST_RUNS = LIST_RUNS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_is_break,
    input  logic [SIZE_W-1:0] s_run_width,
    input  logic [SIZE_W-1:0] s_run_height,
    input  logic              s_last_run,
    output logic              q_push,
    output cmd_t              q_cmd,
    input  logic              q_full
);

    localparam int FW = $clog2(LINE_RUNS + 1);
    localparam int CW = $clog2(LIST_RUNS);

    logic [POS_W-1:0]  pen_x_reg, pen_x_next;
    logic [SIZE_W-1:0] lh_reg, lh_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    logic [CW+IDX_W-1:0] idx_ext;
    logic                box_ok;
    logic [POS_W-1:0]    new_pen;
    logic [SIZE_W-1:0]   hmax;
    logic                closing;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign idx_ext = {{IDX_W{1'b0}}, cnt_reg};

    always_comb begin
        box_ok  = !s_is_break && (fill_reg != FW'(LINE_RUNS));
        new_pen = box_ok ? sat_add(pen_x_reg, s_run_width) : pen_x_reg;
        if ((s_is_break || box_ok) && (s_run_height > lh_reg)) begin
            hmax = s_run_height;
        end else begin
            hmax = lh_reg;
        end
        closing = s_is_break || (s_last_run && ((new_pen != '0) || (hmax != '0)));

        q_cmd.st  = box_ok;
        q_cmd.ovf = !s_is_break && !box_ok && !s_last_run;
        q_cmd.cls = closing;
        q_cmd.sz  = s_last_run;
        q_cmd.idx = idx_ext[IDX_W-1:0];
        q_cmd.x   = pen_x_reg;
        q_cmd.h   = s_run_height;
        q_cmd.lh  = hmax;
        q_cmd.lw  = new_pen;

        pen_x_next = pen_x_reg;
        lh_next    = lh_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        if (q_push) begin
            if (s_last_run) begin
                cnt_next = '0;
            end else if (cnt_reg == CW'(LIST_RUNS - 1)) begin
                cnt_next = '0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (closing || s_last_run) begin
                pen_x_next = '0;
                lh_next    = '0;
                fill_next  = '0;
            end else if (box_ok) begin
                pen_x_next = new_pen;
                lh_next    = hmax;
                fill_next  = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg <= '0;
            lh_reg    <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            pen_x_reg <= pen_x_next;
            lh_reg    <= lh_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/lla_queue.sv */
// Short command queue between the front end and the back end.
module lla_queue
    import lla_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == QCW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/lla_back.sv */
// Back end: holds the line store, flushes closed lines and drives the result register.
module lla_back
    import lla_pkg::*;
#(
    parameter int LINE_RUNS = LINE_RUNS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              q_cmd,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [IDX_W-1:0]  m_run_index,
    output logic [POS_W-1:0]  m_pos_x,
    output logic [POS_W-1:0]  m_pos_y,
    output logic              m_last_result
);

    localparam int FW = $clog2(LINE_RUNS + 1);
    localparam int AW = (LINE_RUNS > 1) ? $clog2(LINE_RUNS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_PLACE = 4'b0100,
        ST_SIZE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    entry_t mem [LINE_RUNS];
    entry_t rdata_reg;
    entry_t wr_entry;
    logic   mem_we;

    cmd_t             cmd_reg, cmd_next;
    logic [FW-1:0]    bfill_reg, bfill_next;
    logic [FW-1:0]    cnt_reg, cnt_next;
    logic [FW-1:0]    ent_reg, ent_next;
    logic [FW-1:0]    count;
    logic [POS_W-1:0] pen_y_reg, pen_y_next;
    logic [POS_W-1:0] widest_reg, widest_next;
    logic             last_ent;

    logic              m_valid_reg;
    kind_t             m_kind_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [POS_W-1:0]  m_x_reg, m_y_reg;
    logic              m_last_reg;

    logic              can_emit, emit;
    kind_t             o_kind;
    logic [IDX_W-1:0]  o_idx;
    logic [POS_W-1:0]  o_x, o_y;
    logic              o_last;

    assign can_emit = !m_valid_reg || m_ready;
    assign count    = bfill_reg + FW'(q_cmd.st);
    assign last_ent = (FW'(ent_reg + 1'b1) == cnt_reg);
    assign wr_entry = '{idx: q_cmd.idx, x: q_cmd.x, h: q_cmd.h};

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        bfill_next  = bfill_reg;
        cnt_next    = cnt_reg;
        ent_next    = ent_reg;
        pen_y_next  = pen_y_reg;
        widest_next = widest_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        emit        = 1'b0;
        o_kind      = KIND_PLACE;
        o_idx       = '0;
        o_x         = '0;
        o_y         = '0;
        o_last      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty && can_emit) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.st) begin
                        mem_we     = 1'b1;
                        bfill_next = bfill_reg + 1'b1;
                    end
                    if (q_cmd.ovf) begin
                        emit   = 1'b1;
                        o_kind = KIND_OVERFLOW;
                        o_idx  = q_cmd.idx;
                        o_last = 1'b1;
                    end
                    if (q_cmd.cls) begin
                        bfill_next = '0;
                        if (count != '0) begin
                            cnt_next   = count;
                            ent_next   = '0;
                            state_next = ST_READ;
                        end else begin
                            // A line with no boxes only advances the pen and updates the widest line.
                            pen_y_next = sat_add(pen_y_reg, q_cmd.lh);
                            if (q_cmd.lw > widest_reg) begin
                                widest_next = q_cmd.lw;
                            end
                            state_next = q_cmd.sz ? ST_SIZE : ST_IDLE;
                        end
                    end else if (q_cmd.sz) begin
                        // An empty trailing line is not closed: its boxes are forgotten.
                        bfill_next = '0;
                        state_next = ST_SIZE;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_PLACE;
            end
            ST_PLACE: begin
                if (can_emit) begin
                    emit   = 1'b1;
                    o_kind = KIND_PLACE;
                    o_idx  = rdata_reg.idx;
                    o_x    = rdata_reg.x;
                    o_y    = sat_add(pen_y_reg, cmd_reg.lh - rdata_reg.h);
                    o_last = last_ent && !cmd_reg.sz;
                    if (last_ent) begin
                        ent_next   = '0;
                        pen_y_next = sat_add(pen_y_reg, cmd_reg.lh);
                        if (cmd_reg.lw > widest_reg) begin
                            widest_next = cmd_reg.lw;
                        end
                        state_next = cmd_reg.sz ? ST_SIZE : ST_IDLE;
                    end else begin
                        ent_next = ent_reg + 1'b1;
                    end
                end
            end
            ST_SIZE: begin
                if (can_emit) begin
                    emit        = 1'b1;
                    o_kind      = KIND_SIZE;
                    o_x         = widest_reg;
                    o_y         = pen_y_reg;
                    o_last      = 1'b1;
                    pen_y_next  = '0;
                    widest_next = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[bfill_reg[AW-1:0]] <= wr_entry;
        end
        rdata_reg <= mem[ent_next[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bfill_reg   <= '0;
            cnt_reg     <= '0;
            ent_reg     <= '0;
            pen_y_reg   <= '0;
            widest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            bfill_reg  <= bfill_next;
            cnt_reg    <= cnt_next;
            ent_reg    <= ent_next;
            pen_y_reg  <= pen_y_next;
            widest_reg <= widest_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (emit) begin
            m_kind_reg <= o_kind;
            m_idx_reg  <= o_idx;
            m_x_reg    <= o_x;
            m_y_reg    <= o_y;
            m_last_reg <= o_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_run_index   = m_idx_reg;
    assign m_pos_x       = m_x_reg;
    assign m_pos_y       = m_y_reg;
    assign m_last_result = m_last_reg;

endmodule

/* tb/tb_line_layout_bottom_align.sv */
// Self-checking testbench for the bottom-aligned line layout block.
`timescale 1ns / 1ps

module tb_line_layout_bottom_align;
    import lla_pkg::*;

    // The line store depth and the list length are the block's defaults. The run index
    // is 10 bits wide, so it wraps by itself at 1024, just as the block's counter does.
    localparam int LINE_CAP    = LINE_RUNS_DEF;
    localparam int RANDOM_RUNS = 390;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 120;
    localparam logic [POS_W-1:0]  POS_TOP  = {POS_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_TOP = {SIZE_W{1'b1}};

    // One result transaction, as it is expected on the m_ channel.
    typedef struct {
        kind_t             kind;
        logic [IDX_W-1:0]  index;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic              tail;
    } layout_result_t;

    // One row of the directed script. Where n_typed is non-zero, the results of the row
    // are written out by hand and take the place of the predicted ones.
    typedef struct {
        logic              brk;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic              last;
        int                n_typed;
        layout_result_t    typed0;
        layout_result_t    typed1;
    } script_row_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_is_break;
    logic [SIZE_W-1:0] s_run_width;
    logic [SIZE_W-1:0] s_run_height;
    logic              s_last_run;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_kind;
    logic [IDX_W-1:0]  m_run_index;
    logic [POS_W-1:0]  m_pos_x;
    logic [POS_W-1:0]  m_pos_y;
    logic              m_last_result;

    // Layout state of the predictor: the pen, the widest line so far, the open line and
    // the boxes that wait in it for their y.
    logic [POS_W-1:0]  pen_x;
    logic [POS_W-1:0]  pen_y;
    logic [POS_W-1:0]  widest;
    logic [SIZE_W-1:0] line_h;
    int                line_fill;
    logic [IDX_W-1:0]  next_index;
    logic [IDX_W-1:0]  held_index [LINE_CAP];
    logic [POS_W-1:0]  held_x     [LINE_CAP];
    logic [SIZE_W-1:0] held_h     [LINE_CAP];

    layout_result_t    awaited [$];
    script_row_t       script  [$];
    int                mismatches   = 0;
    int                results_seen = 0;
    int                runs_played  = 0;
    bit                calm         = 1'b0;

    line_layout_bottom_align u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_is_break    (s_is_break),
        .s_run_width   (s_run_width),
        .s_run_height  (s_run_height),
        .s_last_run    (s_last_run),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_run_index   (m_run_index),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_last_result (m_last_result)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The whole run is bounded; a block that hangs is reported as a failure here.
    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic layout_result_t mk_result(input kind_t kind,
                                                 input logic [IDX_W-1:0] index,
                                                 input logic [POS_W-1:0] x,
                                                 input logic [POS_W-1:0] y,
                                                 input logic tail);
        layout_result_t r;
        r.kind  = kind;
        r.index = index;
        r.x     = x;
        r.y     = y;
        r.tail  = tail;
        return r;
    endfunction

    // Positions saturate at the top of the Q8.12 range rather than wrapping.
    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] sum;
        sum = a + b;
        return sum[POS_W] ? POS_TOP : sum[POS_W-1:0];
    endfunction

    // Mostly full-range values, with a fair share of zero, the maximum and small sizes.
    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SIZE_TOP;
            2, 3:    return SIZE_W'($urandom_range(1, 16'h1000));
            default: return SIZE_W'($urandom);
        endcase
    endfunction

    task automatic clear_layout();
        pen_x      = '0;
        pen_y      = '0;
        widest     = '0;
        line_h     = '0;
        line_fill  = 0;
        next_index = '0;
    endtask

    // Every box of the open line is bottom-aligned to the line height: its top sits as
    // far below the line's top as it is shorter than the tallest item.
    task automatic close_line();
        for (int i = 0; i < line_fill; i++)
            awaited.push_back(mk_result(KIND_PLACE, held_index[i], held_x[i],
                                        pos_add(pen_y, POS_W'(line_h - held_h[i])), 1'b0));
        if (pen_x > widest)
            widest = pen_x;
        pen_y     = pos_add(pen_y, POS_W'(line_h));
        pen_x     = '0;
        line_h    = '0;
        line_fill = 0;
    endtask

    // Works out the results that one accepted run causes and queues them in order.
    task automatic layout_run(input logic brk, input logic [SIZE_W-1:0] w,
                              input logic [SIZE_W-1:0] h, input logic last);
        logic [IDX_W-1:0] index;
        int               first;
        index      = next_index;
        first      = awaited.size();
        next_index = next_index + 1'b1;
        if (brk) begin
            if (h > line_h)
                line_h = h;
            close_line();
        end else if (line_fill >= LINE_CAP) begin
            // A dropped box is reported, except on the last run, where the flush and
            // the size result must fit in the result budget.
            if (!last)
                awaited.push_back(mk_result(KIND_OVERFLOW, index, '0, '0, 1'b0));
        end else begin
            held_index[line_fill] = index;
            held_x[line_fill]     = pen_x;
            held_h[line_fill]     = h;
            line_fill++;
            pen_x = pos_add(pen_x, POS_W'(w));
            if (h > line_h)
                line_h = h;
        end
        if (last) begin
            // A trailing line with neither width nor height is simply forgotten.
            if (pen_x != '0 || line_h != '0)
                close_line();
            awaited.push_back(mk_result(KIND_SIZE, '0, widest, pen_y, 1'b0));
            clear_layout();
        end
        if (awaited.size() > first)
            awaited[awaited.size() - 1].tail = 1'b1;
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_result(input layout_result_t got);
        layout_result_t want;
        if (awaited.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, kind %0d index %0d",
                                    got.kind, got.index));
            return;
        end
        want = awaited.pop_front();
        if (got.kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.index !== want.index)
            flag_mismatch($sformatf("run_index %0d, expected %0d", got.index, want.index));
        if (got.x !== want.x)
            flag_mismatch($sformatf("pos_x %h, expected %h (index %0d)",
                                    got.x, want.x, want.index));
        if (got.y !== want.y)
            flag_mismatch($sformatf("pos_y %h, expected %h (index %0d)",
                                    got.y, want.y, want.index));
        if (got.tail !== want.tail)
            flag_mismatch($sformatf("last_result %b, expected %b (index %0d)",
                                    got.tail, want.tail, want.index));
    endtask

    // Offers one run on the s_ channel and returns at the edge that accepts it. The
    // handshake is sampled at the falling edge, where every signal has settled, and the
    // transaction completes at the rising edge that follows. Called at a rising edge.
    task automatic send_run(input logic brk, input logic [SIZE_W-1:0] w,
                            input logic [SIZE_W-1:0] h, input logic last);
        int gap;
        bit took;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_is_break   <= brk;
        s_run_width  <= w;
        s_run_height <= h;
        s_last_run   <= last;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
    endtask

    task automatic play(input logic brk, input logic [SIZE_W-1:0] w,
                        input logic [SIZE_W-1:0] h, input logic last);
        send_run(brk, w, h, last);
        layout_run(brk, w, h, last);
        runs_played++;
    endtask

    task automatic add_row(input logic brk, input logic [SIZE_W-1:0] w,
                           input logic [SIZE_W-1:0] h, input logic last, input int n_typed,
                           input layout_result_t typed0, input layout_result_t typed1);
        script_row_t row;
        row.brk     = brk;
        row.w       = w;
        row.h       = h;
        row.last    = last;
        row.n_typed = n_typed;
        row.typed0  = typed0;
        row.typed1  = typed1;
        script.push_back(row);
    endtask

    // An ordinary list: a few lines of a few boxes, mostly ended by breaks, and one of
    // the three ways of ending a list.
    task automatic normal_list();
        int lines;
        int boxes;
        lines = $urandom_range(1, 4);
        for (int l = 0; l < lines; l++) begin
            boxes = $urandom_range(0, 6);
            for (int b = 0; b < boxes; b++)
                play(1'b0, rand_size(), rand_size(), 1'b0);
            if (l < lines - 1 || $urandom_range(0, 1))
                play(1'b1, rand_size(), ($urandom_range(0, 3) == 0) ? '0 : rand_size(), 1'b0);
        end
        case ($urandom_range(0, 2))
            0:       play(1'b0, rand_size(), rand_size(), 1'b1);
            1:       play(1'b1, rand_size(), rand_size(), 1'b1);
            default: play(1'b0, '0, '0, 1'b1);
        endcase
    endtask

    // One long line that may run past the line store. With end_on_box the last run is a
    // box, which lands on a full store when there are more boxes than the store holds.
    task automatic full_list(input int boxes, input bit end_on_box, input bit wide);
        for (int b = 0; b < boxes - (end_on_box ? 1 : 0); b++)
            play(1'b0, wide ? SIZE_TOP - SIZE_W'($urandom_range(0, 3)) : rand_size(),
                 rand_size(), 1'b0);
        if (end_on_box)
            play(1'b0, rand_size(), rand_size(), 1'b1);
        else
            play(1'b1, rand_size(), rand_size(), 1'b1);
    endtask

    // Tall lines that drive the pen y into saturation whenever there are more than sixteen.
    task automatic tall_list();
        int lines;
        lines = $urandom_range(16, 20);
        for (int l = 0; l < lines; l++) begin
            play(1'b0, rand_size(), SIZE_TOP - SIZE_W'($urandom_range(0, 255)), 1'b0);
            play(1'b1, rand_size(), SIZE_TOP, 1'b0);
        end
        play(1'b0, rand_size(), rand_size(), 1'b1);
    endtask

    // Arbitrary runs with no regard for list structure.
    task automatic noise_list();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            play($urandom_range(0, 2) == 0, SIZE_W'($urandom), SIZE_W'($urandom),
                 $urandom_range(0, 5) == 0);
    endtask

    // The result side: it draws a stall before every result, and once holds off for a
    // long stretch so that the block fills up and has to stall the s_ channel. As with
    // the sender, the handshake is sampled at the falling edge.
    initial begin : result_sink
        int             stall;
        bit             took;
        layout_result_t got;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                took = m_valid;
                got  = mk_result(kind_t'(m_kind), m_run_index, m_pos_x, m_pos_y,
                                 m_last_result);
                @(posedge aclk);
            end while (!took);
            results_seen++;
            check_result(got);
        end
    end

    initial begin : stimulus
        layout_result_t blank;
        int             first;
        int             lists_done;
        blank = mk_result(KIND_PLACE, '0, '0, '0, 1'b0);

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_is_break   <= 1'b0;
        s_run_width  <= '0;
        s_run_height <= '0;
        s_last_run   <= 1'b0;
        clear_layout();

        // Single-run lists first: each ends its own list, so each starts from a cleared layout and
        // its results can be written down directly.
        // An empty box alone: the trailing line has no width or height and is dropped.
        add_row(1'b0, '0, '0, 1'b1, 1, mk_result(KIND_SIZE, '0, '0, '0, 1'b1), blank);
        // A zero-height break that ends the list: nothing but an empty size.
        add_row(1'b1, '0, '0, 1'b1, 1, mk_result(KIND_SIZE, '0, '0, '0, 1'b1), blank);
        // The largest box.
        add_row(1'b0, SIZE_TOP, SIZE_TOP, 1'b1, 2,
                mk_result(KIND_PLACE, '0, '0, '0, 1'b0),
                mk_result(KIND_SIZE, '0, POS_W'(SIZE_TOP), POS_W'(SIZE_TOP), 1'b1));
        // The tallest break: it adds height but no width.
        add_row(1'b1, SIZE_TOP, SIZE_TOP, 1'b1, 1,
                mk_result(KIND_SIZE, '0, '0, POS_W'(SIZE_TOP), 1'b1), blank);
        // A box with height only, and one with width only: both lines are closed.
        add_row(1'b0, '0, 16'd5, 1'b1, 2, mk_result(KIND_PLACE, '0, '0, '0, 1'b0),
                mk_result(KIND_SIZE, '0, '0, 20'd5, 1'b1));
        add_row(1'b0, 16'd7, '0, 1'b1, 2, mk_result(KIND_PLACE, '0, '0, '0, 1'b0),
                mk_result(KIND_SIZE, '0, 20'd7, '0, 1'b1));
        // Two lines of mixed heights, a break taller than its line, an empty line, a
        // zero box and a tall break; the predictor covers these.
        add_row(1'b0, 16'h1000, 16'h2000, 1'b0, 0, blank, blank);
        add_row(1'b0, 16'h3000, 16'h8000, 1'b0, 0, blank, blank);
        add_row(1'b0, SIZE_TOP, 16'h0001, 1'b0, 0, blank, blank);
        add_row(1'b1, 16'h0F0F, 16'h9000, 1'b0, 0, blank, blank);
        add_row(1'b1, '0, '0, 1'b0, 0, blank, blank);
        add_row(1'b0, 16'hABCD, 16'h1234, 1'b0, 0, blank, blank);
        add_row(1'b0, '0, '0, 1'b0, 0, blank, blank);
        add_row(1'b1, '0, SIZE_TOP, 1'b0, 0, blank, blank);
        add_row(1'b0, 16'h5555, 16'hAAAA, 1'b1, 0, blank, blank);
        // A break, then an empty box that ends the list on an empty trailing line.
        add_row(1'b1, 16'h0003, 16'h0003, 1'b0, 0, blank, blank);
        add_row(1'b0, '0, '0, 1'b1, 0, blank, blank);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            send_run(script[i].brk, script[i].w, script[i].h, script[i].last);
            // No time passes between the accepting edge and the prediction, so the
            // results of this row are the newest entries of the queue.
            first = awaited.size();
            layout_run(script[i].brk, script[i].w, script[i].h, script[i].last);
            if (script[i].n_typed > 0) begin
                while (awaited.size() > first)
                    void'(awaited.pop_back());
                awaited.push_back(script[i].typed0);
                if (script[i].n_typed > 1)
                    awaited.push_back(script[i].typed1);
            end
        end

        // Random lists. The first two are fixed in shape: a line that overflows and is
        // closed by a break, and one whose last box lands on a full store. Calm lists
        // run with no idling on either side.
        lists_done = 0;
        while (runs_played < RANDOM_RUNS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (lists_done == 0)
                full_list(LINE_CAP + 1, 1'b0, 1'b1);
            else if (lists_done == 1)
                full_list(LINE_CAP + 1, 1'b1, 1'b0);
            else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: normal_list();
                    6:       full_list($urandom_range(LINE_CAP - 4, LINE_CAP + 4),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    7:       tall_list();
                    default: noise_list();
                endcase
            end
            lists_done++;
        end
        // Close whatever the noise may have left open.
        play(1'b0, rand_size(), rand_size(), 1'b1);
        s_valid <= 1'b0;

        while (awaited.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/lla_pkg.sv
rtl/lla_front.sv
rtl/lla_queue.sv
rtl/lla_back.sv
rtl/line_layout_bottom_align.sv
tb/tb_line_layout_bottom_align.sv
